FILE: rtl/hrcc_pkg.sv
// types and constants for the http request completeness checker
// used by http_request_completeness_check_core, no dependencies
package hrcc_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CLEN_W = 16;
	// result word: complete, header_done, content_length, bad_length, padded to bytes
	localparam int unsigned RES_W  = 24;

	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_LF    = 8'h0a;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_VT    = 8'h0b;
	localparam logic [7:0] CHAR_FF    = 8'h0c;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_PLUS  = 8'h2b;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_COLON = 8'h3a;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_UP_A  = 8'h41;
	localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
	localparam logic [7:0] CASE_BIT   = 8'h20;

	// length of the header name "content-length"
	localparam logic [3:0] NAME_LEN = 4'd14;

	typedef enum logic [2:0] {
		PH_REQ  = 3'b001,
		PH_HDR  = 3'b010,
		PH_BODY = 3'b100
	} parse_phase_t;

	typedef enum logic [4:0] {
		VP_NONE   = 5'b00001,
		VP_LEAD   = 5'b00010,
		VP_SIGNED = 5'b00100,
		VP_DIGITS = 5'b01000,
		VP_DONE   = 5'b10000
	} value_phase_t;

	// lower-case "content-length", one character per match position
	function automatic logic [7:0] name_char(logic [3:0] pos);
		logic [7:0] ch;
		unique case (pos)
			4'd0:    ch = 8'h63; // c
			4'd1:    ch = 8'h6f; // o
			4'd2:    ch = 8'h6e; // n
			4'd3:    ch = 8'h74; // t
			4'd4:    ch = 8'h65; // e
			4'd5:    ch = 8'h6e; // n
			4'd6:    ch = 8'h74; // t
			4'd7:    ch = 8'h2d; // -
			4'd8:    ch = 8'h6c; // l
			4'd9:    ch = 8'h65; // e
			4'd10:   ch = 8'h6e; // n
			4'd11:   ch = 8'h67; // g
			4'd12:   ch = 8'h74; // t
			4'd13:   ch = 8'h68; // h
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

FILE: rtl/http_request_completeness_check_core.sv
// an input byte waits in the input register, its result then in the result register,
// from which the result transaction completes while m_tready is high
// throughput: one byte per cycle while m_tready is high; each input yields one result
// the parser state loads with the result register, from the byte in the input register
// m_tready low stalls the result register and, through it, the input register
// arst_n clears all valid bits and parser state at once; no clearing pass
// a transaction with s_tuser set restarts the parser before its byte is taken
module http_request_completeness_check_core #(
	parameter int unsigned MAX_CONTENT_LENGTH = 65535
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [hrcc_pkg::BYTE_W-1:0]        s_tdata,  // [7:0] data_byte
	input  logic                               s_tuser,  // [0] first
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [hrcc_pkg::RES_W-1:0]         m_tdata   // [0] complete, [1] header_done,
	                                                     // [17:2] content_length,
	                                                     // [18] bad_length, [23:19] zero
);
	import hrcc_pkg::*;

	// width of the length accumulator and body counter
	localparam int unsigned LEN_W  = $clog2(64'(MAX_CONTENT_LENGTH) + 64'd1);
	// accumulator times ten plus a digit
	localparam int unsigned PROD_W = LEN_W + 4;
	localparam logic [LEN_W-1:0]  MAX_L = LEN_W'(MAX_CONTENT_LENGTH);
	localparam logic [PROD_W-1:0] MAX_P = PROD_W'(MAX_CONTENT_LENGTH);

	// input register
	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              first_s1;

	// result register
	logic              valid_s2;
	logic [RES_W-1:0]  res_s2;

	// parser state
	parse_phase_t      phase_q;
	logic              prior_lf_q;
	logic              colon_q;
	logic [3:0]        match_pos_q;
	logic              mismatch_q;
	value_phase_t      vphase_q;
	logic              negative_q;
	logic              found_q;
	logic [LEN_W-1:0]  accum_q;
	logic [LEN_W-1:0]  body_q;
	logic              error_q;

	// state seen by the byte (after a restart) and next state
	parse_phase_t      phase_c,    phase_d;
	logic              prior_lf_c, prior_lf_d;
	logic              colon_c,    colon_d;
	logic [3:0]        match_pos_c, match_pos_d;
	logic              mismatch_c, mismatch_d;
	value_phase_t      vphase_c,   vphase_d;
	logic              negative_c, negative_d;
	logic              found_c,    found_d;
	logic [LEN_W-1:0]  accum_c,    accum_d;
	logic [LEN_W-1:0]  body_c,     body_d;
	logic              error_c,    error_d;

	logic              advance;
	logic              is_digit;
	logic              is_blank;
	logic              is_sign;
	logic [7:0]        lower_c;
	logic [PROD_W-1:0] accum_ext;
	logic [PROD_W-1:0] prod;
	logic [LEN_W-1:0]  eff_len;
	logic              done;
	logic              complete;
	logic [31:0]       eff_wide;
	logic [RES_W-1:0]  res_d;

	// result register frees up when empty or when its transaction completes
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2;

	// character classes
	assign is_digit  = (data_s1 >= CHAR_ZERO) && (data_s1 <= CHAR_NINE);
	assign is_blank  = (data_s1 == CHAR_SPACE) || (data_s1 == CHAR_TAB) ||
	                   (data_s1 == CHAR_VT) || (data_s1 == CHAR_FF);
	assign is_sign   = (data_s1 == CHAR_PLUS) || (data_s1 == CHAR_MINUS);
	assign lower_c   = ((data_s1 >= CHAR_UP_A) && (data_s1 <= CHAR_UP_Z)) ?
	                   (data_s1 | CASE_BIT) : data_s1;

	// restart on the first byte of a request
	always_comb begin
		if (first_s1) begin
			phase_c     = PH_REQ;
			prior_lf_c  = 1'b0;
			colon_c     = 1'b0;
			match_pos_c = 4'd0;
			mismatch_c  = 1'b0;
			vphase_c    = VP_NONE;
			negative_c  = 1'b0;
			found_c     = 1'b0;
			accum_c     = '0;
			body_c      = '0;
			error_c     = 1'b0;
		end else begin
			phase_c     = phase_q;
			prior_lf_c  = prior_lf_q;
			colon_c     = colon_q;
			match_pos_c = match_pos_q;
			mismatch_c  = mismatch_q;
			vphase_c    = vphase_q;
			negative_c  = negative_q;
			found_c     = found_q;
			accum_c     = accum_q;
			body_c      = body_q;
			error_c     = error_q;
		end
	end

	// accumulator * 10 + digit, by shifts
	assign accum_ext = PROD_W'(accum_c);
	assign prod      = (accum_ext << 3) + (accum_ext << 1) + PROD_W'(data_s1 - CHAR_ZERO);

	// per-byte parser update
	always_comb begin
		phase_d     = phase_c;
		prior_lf_d  = prior_lf_c;
		colon_d     = colon_c;
		match_pos_d = match_pos_c;
		mismatch_d  = mismatch_c;
		vphase_d    = vphase_c;
		negative_d  = negative_c;
		found_d     = found_c;
		accum_d     = accum_c;
		body_d      = body_c;
		error_d     = error_c;

		// carriage returns change nothing
		if (data_s1 != CHAR_CR) begin
			priority if (phase_c == PH_BODY) begin
				if (body_c < MAX_L) begin
					body_d = body_c + LEN_W'(1);
				end
			end else if (data_s1 == CHAR_LF) begin
				priority if (phase_c == PH_REQ) begin
					phase_d = PH_HDR;
				end else if (prior_lf_c) begin
					phase_d = PH_BODY;
				end else begin
					// line ended inside a value with no digits yet
					if (vphase_c == VP_LEAD || vphase_c == VP_SIGNED) begin
						error_d = 1'b1;
					end
					vphase_d = VP_NONE;
				end
				colon_d     = 1'b0;
				match_pos_d = 4'd0;
				mismatch_d  = 1'b0;
				prior_lf_d  = 1'b1;
			end else begin
				prior_lf_d = 1'b0;
				if (phase_c == PH_HDR) begin
					priority if (vphase_c != VP_NONE) begin
						// length value, read like stoi
						if (vphase_c == VP_LEAD && is_blank) begin
							vphase_d = VP_LEAD;
						end else if (vphase_c == VP_LEAD && is_sign) begin
							negative_d = (data_s1 == CHAR_MINUS);
							vphase_d   = VP_SIGNED;
						end else if (vphase_c != VP_DONE) begin
							if (is_digit) begin
								if (prod > MAX_P) begin
									accum_d = MAX_L;
									if (!negative_c) begin
										error_d = 1'b1;
									end
								end else begin
									accum_d = prod[LEN_W-1:0];
								end
								vphase_d = VP_DIGITS;
							end else begin
								if (vphase_c != VP_DIGITS) begin
									error_d = 1'b1;
								end
								vphase_d = VP_DONE;
							end
						end
					end else if (colon_c) begin
						// rest of the line is ignored
						colon_d = colon_c;
					end else if (data_s1 == CHAR_COLON) begin
						colon_d = 1'b1;
						if (!mismatch_c && match_pos_c == NAME_LEN && !found_c) begin
							found_d  = 1'b1;
							vphase_d = VP_LEAD;
						end
					end else if (mismatch_c) begin
						mismatch_d = mismatch_c;
					end else if (match_pos_c >= NAME_LEN) begin
						mismatch_d = 1'b1;
					end else if (lower_c == name_char(match_pos_c)) begin
						match_pos_d = match_pos_c + 4'd1;
					end else begin
						mismatch_d = 1'b1;
					end
				end
			end
		end
	end

	// result from the updated state
	assign eff_len  = (!found_d || negative_d) ? '0 : accum_d;
	assign done     = (phase_d == PH_BODY);
	assign complete = done && (body_d >= eff_len);
	assign eff_wide = 32'(eff_len);
	assign res_d    = {5'd0, error_d, eff_wide[CLEN_W-1:0], done, complete};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1  <= s_tdata;
			first_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_REQ;
			prior_lf_q  <= 1'b0;
			colon_q     <= 1'b0;
			match_pos_q <= 4'd0;
			mismatch_q  <= 1'b0;
			vphase_q    <= VP_NONE;
			negative_q  <= 1'b0;
			found_q     <= 1'b0;
			accum_q     <= '0;
			body_q      <= '0;
			error_q     <= 1'b0;
		end else if (advance) begin
			phase_q     <= phase_d;
			prior_lf_q  <= prior_lf_d;
			colon_q     <= colon_d;
			match_pos_q <= match_pos_d;
			mismatch_q  <= mismatch_d;
			vphase_q    <= vphase_d;
			negative_q  <= negative_d;
			found_q     <= found_d;
			accum_q     <= accum_d;
			body_q      <= body_d;
			error_q     <= error_d;
		end
	end

`ifndef ASSERT_OFF
	// a complete request always has its header finished
	a_complete_needs_header: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[0] || m_tdata[1]))
		else $error("complete without header_done");

	// a length error only comes from a content-length value
	a_error_needs_found: assert property (@(posedge clk) disable iff (!arst_n)
		error_q |-> found_q)
		else $error("length error without content-length line");

	// body bytes are only counted after the header
	a_body_only_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		(body_q != '0) |-> (phase_q == PH_BODY))
		else $error("body count outside body phase");

	// a value is only parsed on a header line
	a_value_only_in_header: assert property (@(posedge clk) disable iff (!arst_n)
		(vphase_q != VP_NONE) |-> (phase_q == PH_HDR))
		else $error("value parse outside header phase");

	// every parser update leaves a result behind
	a_advance_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("update without result");
`endif

endmodule

FILE: bench/request_status_check.sv
// status checker for the http request completeness core: rebuilds the parser state,
// predicts every result transaction and compares it field by field
// depends on hrcc_pkg for widths, character codes and phase enums
module request_status_check (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [hrcc_pkg::BYTE_W-1:0] s_tdata,     // [7:0] data_byte
	input  logic                        s_tuser,     // [0] first
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [hrcc_pkg::RES_W-1:0]  m_tdata,     // [0] complete, [1] header_done,
	                                                 // [17:2] content_length, [18] bad_length
	output int                          mismatches,
	output int                          statuses,
	output int                          completes,
	output int                          bad_lengths
);
	import hrcc_pkg::*;

	localparam logic [CLEN_W-1:0] LEN_MAX    = 16'hffff;
	localparam logic [0:13][7:0]  FIELD_NAME = "content-length";

	typedef struct packed {
		logic [4:0]        pad;
		logic              bad;
		logic [CLEN_W-1:0] clen;
		logic              hdr;
		logic              done;
	} status_t;

	parse_phase_t      phase;
	value_phase_t      vphase;
	logic              last_lf;
	logic              colon_on_line;
	logic [3:0]        match_pos;
	logic              name_miss;
	logic              neg;
	logic              len_seen;
	logic [CLEN_W-1:0] accum;
	logic [CLEN_W-1:0] body_cnt;
	logic              len_err;

	status_t pending[$];
	int      fresh;

	function automatic void clear_parse();
		phase         = PH_REQ;
		vphase        = VP_NONE;
		last_lf       = 1'b0;
		colon_on_line = 1'b0;
		match_pos     = '0;
		name_miss     = 1'b0;
		neg           = 1'b0;
		len_seen      = 1'b0;
		accum         = '0;
		body_cnt      = '0;
		len_err       = 1'b0;
	endfunction

	// stoi-like reading of the length value
	function automatic void value_char(input logic [7:0] c);
		logic        digit;
		logic [19:0] v;
		digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
		if (vphase == VP_LEAD) begin
			if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF)
				return;
			if (c == CHAR_PLUS || c == CHAR_MINUS) begin
				neg    = (c == CHAR_MINUS);
				vphase = VP_SIGNED;
				return;
			end
		end
		if (vphase == VP_LEAD || vphase == VP_SIGNED || vphase == VP_DIGITS) begin
			if (digit) begin
				v = accum * 20'd10 + 20'(c - CHAR_ZERO);
				if (v > 20'(LEN_MAX)) begin
					v = 20'(LEN_MAX);
					if (!neg)
						len_err = 1'b1;
				end
				accum  = v[CLEN_W-1:0];
				vphase = VP_DIGITS;
			end else begin
				if (vphase != VP_DIGITS)
					len_err = 1'b1;
				vphase = VP_DONE;
			end
		end
	endfunction

	function automatic void header_char(input logic [7:0] c);
		logic [7:0] lc;
		if (vphase != VP_NONE) begin
			value_char(c);
			return;
		end
		if (colon_on_line)
			return;
		if (c == CHAR_COLON) begin
			colon_on_line = 1'b1;
			if (!name_miss && match_pos == NAME_LEN && !len_seen) begin
				len_seen = 1'b1;
				vphase   = VP_LEAD;
			end
			return;
		end
		if (name_miss)
			return;
		if (match_pos >= NAME_LEN) begin
			name_miss = 1'b1;
			return;
		end
		lc = (c >= CHAR_UP_A && c <= CHAR_UP_Z) ? (c | CASE_BIT) : c;
		if (lc == FIELD_NAME[match_pos])
			match_pos++;
		else
			name_miss = 1'b1;
	endfunction

	function automatic status_t next_status(input logic [7:0] c, input logic first);
		status_t           st;
		logic [CLEN_W-1:0] eff;
		if (first)
			clear_parse();
		if (c != CHAR_CR) begin
			if (phase == PH_BODY) begin
				if (body_cnt != LEN_MAX)
					body_cnt++;
			end else if (c == CHAR_LF) begin
				if (phase == PH_REQ) begin
					phase = PH_HDR;
				end else if (last_lf) begin
					phase = PH_BODY;
				end else begin
					if (vphase == VP_LEAD || vphase == VP_SIGNED)
						len_err = 1'b1;
					vphase = VP_NONE;
				end
				colon_on_line = 1'b0;
				match_pos     = '0;
				name_miss     = 1'b0;
				last_lf       = 1'b1;
			end else begin
				if (phase == PH_HDR)
					header_char(c);
				last_lf = 1'b0;
			end
		end
		eff     = (!len_seen || neg) ? '0 : accum;
		st      = '0;
		st.done = (phase == PH_BODY) && (body_cnt >= eff);
		st.hdr  = (phase == PH_BODY);
		st.clen = eff;
		st.bad  = len_err;
		return st;
	endfunction

	task automatic check_field(input string fname, input int unsigned want, got);
		if (want != got) begin
			if (mismatches + fresh < 10)
				$display("status %0d: %s expected %0d, got %0d", statuses, fname, want, got);
			fresh++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		status_t got;
		status_t want;
		if (!arst_n) begin
			clear_parse();
			pending.delete();
			mismatches  <= 0;
			statuses    <= 0;
			completes   <= 0;
			bad_lengths <= 0;
		end else begin
			fresh = 0;
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (pending.size() == 0) begin
					if (mismatches < 10)
						$display("status %0d: result %h with nothing pending", statuses, m_tdata);
					fresh = 1;
				end else begin
					want = pending.pop_front();
					check_field("complete", want.done, got.done);
					check_field("header_done", want.hdr, got.hdr);
					check_field("content_length", want.clen, got.clen);
					check_field("bad_length", want.bad, got.bad);
					check_field("padding", want.pad, got.pad);
				end
				statuses    <= statuses + 1;
				completes   <= completes + int'(got.done);
				bad_lengths <= bad_lengths + int'(got.bad);
			end
			if (s_tvalid && s_tready)
				pending.push_back(next_status(s_tdata, s_tuser));
			mismatches <= mismatches + fresh;
		end
	end

endmodule

FILE: bench/http_request_completeness_check_core_test.sv
// top of the bench for http_request_completeness_check_core: builds request text,
// drives it byte by byte with bursts and gaps, stalls the result side, gives the verdict
// depends on hrcc_pkg, the core and request_status_check
module http_request_completeness_check_core_test;
	import hrcc_pkg::*;

	localparam int ITEM_GOAL = 1750;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [BYTE_W-1:0]   s_tdata  = '0;     // [7:0] data_byte
	logic                s_tuser  = 1'b0;   // [0] first
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [RES_W-1:0]    m_tdata;           // [0] complete, [1] header_done,
	                                        // [17:2] content_length, [18] bad_length

	int mismatches;
	int statuses;
	int completes;
	int bad_lengths;

	// request text waiting to go out, one entry per byte
	logic [7:0] req_bytes[$];
	int         bytes_sent  = 0;
	int         requests    = 0;
	int         burst_left  = 0;
	int         rx_mode     = 0;
	int         rx_left     = 0;

	always #1 clk = ~clk;

	http_request_completeness_check_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	request_status_check u_status (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.statuses    (statuses),
		.completes   (completes),
		.bad_lengths (bad_lengths)
	);

	// result side: the stall mode is drawn anew whenever its countdown runs out, from always ready
	// down to ready with a chance of one in eight
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 200);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= ($urandom_range(0, 3) != 0);
			2:       m_tready <= ($urandom_range(0, 1) != 0);
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// printable header text, never a colon, CR or LF
	function automatic logic [7:0] text_char();
		logic [7:0] ch;
		ch = 8'($urandom_range(8'h21, 8'h7e));
		return (ch == CHAR_COLON) ? "a" : ch;
	endfunction

	// append one byte; now and then a stray CR goes in ahead of it, which the core must skip
	task automatic put(input logic [7:0] b);
		if ($urandom_range(0, 19) == 0)
			req_bytes.push_back(CHAR_CR);
		req_bytes.push_back(b);
	endtask

	task automatic put_text(input string t);
		for (int i = 0; i < t.len(); i++)
			put(t[i]);
	endtask

	// line end, bare LF or CRLF
	task automatic put_eol();
		if ($urandom_range(0, 1))
			req_bytes.push_back(CHAR_CR);
		req_bytes.push_back(CHAR_LF);
	endtask

	// the header name in random letter case
	task automatic put_length_name();
		string      nm;
		logic [7:0] ch;
		nm = "content-length";
		for (int i = 0; i < nm.len(); i++) begin
			ch = nm[i];
			if (ch != CHAR_MINUS && $urandom_range(0, 1))
				ch = ch ^ CASE_BIT;
			put(ch);
		end
	endtask

	// length value text; usable is the value when a matching body makes sense, else -1
	task automatic put_value(output int usable);
		int   v;
		logic neg;
		usable = -1;
		neg    = 1'b0;
		// leading blanks the parser skips
		repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) begin
			case ($urandom_range(0, 3))
				0:       put(CHAR_SPACE);
				1:       put(CHAR_TAB);
				2:       put(CHAR_VT);
				default: put(CHAR_FF);
			endcase
		end
		case ($urandom_range(0, 11))
			0: put(CHAR_PLUS);
			1: begin
				put(CHAR_MINUS);
				neg = 1'b1;
			end
			2: begin
				// second sign: no digits
				put(CHAR_MINUS);
				put(CHAR_PLUS);
			end
			3: begin
				// blank after the sign: no digits
				put(CHAR_PLUS);
				put(CHAR_SPACE);
			end
			default: ;
		endcase
		case ($urandom_range(0, 9))
			0: begin
				// no digits at all, either junk or an empty value
				if ($urandom_range(0, 1))
					put("x");
			end
			1: begin
				// around and far above the largest length
				v = $urandom_range(0, 1) ? $urandom_range(65530, 65540)
				                         : $urandom_range(100000, 99999999);
				put_text($sformatf("%0d", v));
			end
			2: begin
				v = $urandom_range(0, 20);
				put_text($sformatf("000%0d", v));
				usable = neg ? 0 : v;
			end
			3: begin
				v = $urandom_range(61, 160);
				put_text($sformatf("%0d", v));
				if ($urandom_range(0, 3) == 0)
					usable = neg ? 0 : v;
			end
			default: begin
				v = $urandom_range(0, 40);
				put_text($sformatf("%0d", v));
				usable = neg ? 0 : v;
			end
		endcase
		// trailing junk after the number is ignored
		if ($urandom_range(0, 3) == 0) begin
			put(CHAR_SPACE);
			put(text_char());
		end
	endtask

	// any header line but the one that counts
	task automatic put_other_line(input logic after_length);
		int v;
		case ($urandom_range(0, 5))
			0: begin
				if (after_length) begin
					// a second content-length line is ignored
					put_length_name();
					put(CHAR_COLON);
					put_text($sformatf("%0d", $urandom_range(0, 999)));
				end else begin
					put_text("host:x");
				end
			end
			1: begin
				// names that come close to matching
				case ($urandom_range(0, 4))
					0:       put_text("content-lengt");
					1:       put_text("content-lengthx");
					2:       put_text("content_length");
					3:       put_text(" content-length");
					default: put_text("xcontent-length");
				endcase
				put(CHAR_COLON);
				put_text($sformatf("%0d", $urandom_range(0, 99)));
			end
			2: begin
				// the right name but no colon on the line
				put_length_name();
				put_text(" 5");
			end
			default: begin
				repeat ($urandom_range(1, 6))
					put(text_char());
				put(CHAR_COLON);
				repeat ($urandom_range(0, 5))
					put(text_char());
			end
		endcase
		put_eol();
	endtask

	task automatic build_request();
		int nhdr;
		int len_at;
		int body_len;
		int usable;
		int n;
		req_bytes.delete();
		// a few requests are pure noise, raw bytes with line feeds sprinkled in
		if ($urandom_range(0, 11) == 0) begin
			repeat ($urandom_range(1, 24))
				req_bytes.push_back($urandom_range(0, 5) == 0 ? CHAR_LF : 8'($urandom_range(0, 255)));
			return;
		end
		// request line, skipped by the parser whatever it holds
		case ($urandom_range(0, 2))
			0:       put_text("GET /");
			1:       put_text("POST /");
			default: put_text("PUT /");
		endcase
		repeat ($urandom_range(0, 4))
			put($urandom_range(0, 7) == 0 ? CHAR_COLON : text_char());
		put_eol();
		nhdr     = $urandom_range(0, 3);
		len_at   = $urandom_range(0, nhdr);    // nhdr means no content-length line
		body_len = $urandom_range(0, 5);
		for (int i = 0; i < nhdr; i++) begin
			if (i == len_at) begin
				put_length_name();
				put(CHAR_COLON);
				put_value(usable);
				put_eol();
				if (usable >= 0)
					body_len = usable;
			end else begin
				put_other_line(i > len_at);
			end
		end
		// now and then the header never ends
		if ($urandom_range(0, 19) == 0)
			return;
		put_eol();
		// body: short by one, a little long, or exact
		case ($urandom_range(0, 5))
			0:       n = (body_len > 0) ? body_len - 1 : 0;
			1:       n = body_len + $urandom_range(1, 4);
			default: n = body_len;
		endcase
		repeat (n)
			req_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// directed text, no stray CRs added
	task automatic raw_text(input string t);
		req_bytes.delete();
		for (int i = 0; i < t.len(); i++)
			req_bytes.push_back(t[i]);
	endtask

	// drive the queued request; restart marks its first byte with tuser
	task automatic send_request(input logic restart, input logic quiet);
		int gap;
		for (int i = 0; i < req_bytes.size(); i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap        = quiet ? 0 : $urandom_range(0, 5);
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			s_tdata  <= req_bytes[i];
			s_tuser  <= restart && (i == 0);
			s_tvalid <= 1'b1;
			do @(posedge clk); while (!s_tready);
			bytes_sent++;
			burst_left--;
		end
		requests++;
	endtask

	// hold off until every result for the bytes sent so far has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (statuses != bytes_sent);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// header with no header lines, CR inside the line end, then bytes past completion
		// including both byte extremes
		raw_text("G\r\n\n");
		req_bytes.push_back(8'hff);
		req_bytes.push_back(8'h00);
		send_request(1'b1, 1'b1);
		// odd-case name with a negative value: length counts as zero
		raw_text("\nCONTENT-length:-9\n\n");
		send_request(1'b1, 1'b0);
		drain();

		// random requests, mostly well formed with random content; an occasional one
		// continues the previous request without the restart mark
		while (bytes_sent < ITEM_GOAL) begin
			build_request();
			send_request($urandom_range(0, 15) != 0, $urandom_range(0, 3) == 0);
			if ($urandom_range(0, 14) == 0)
				drain();
		end
		drain();

		// let any stray result show up before the verdict
		repeat (8) @(posedge clk);
		$display("covered %0d requests in %0d bytes; %0d results, %0d complete, %0d bad length",
		         requests, bytes_sent, statuses, completes, bad_lengths);
		if (mismatches == 0)
			$display("http_request_completeness_check_core_test: done, clean");
		else
			$display("http_request_completeness_check_core_test: done, errors");
		$finish;
	end

	// hard stop far beyond the slowest correct run
	initial begin
		#1000000;
		$display("http_request_completeness_check_core_test: done, errors");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/hrcc_pkg.sv
rtl/http_request_completeness_check_core.sv
bench/request_status_check.sv
bench/http_request_completeness_check_core_test.sv
